@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clk edge, masked while rst is high
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/tmpc_pkg.sv @@
`timescale 1ns / 1ps

package tmpc_pkg;

  localparam int TimerWidthDefault = 16;
  localparam int CfgTimerWidth     = 16;
  localparam int BatteryWidth      = 10;
  localparam int PaddrWidth        = 5;
  localparam int ApbDataWidth      = 32;

  // register reset values
  localparam logic [7:0]               DebounceReset     = 8'd32;
  localparam logic [7:0]               HoldReset         = 8'd100;
  localparam logic [BatteryWidth-1:0]  BatteryLowReset   = 10'd675;
  localparam logic [CfgTimerWidth-1:0] PlasmaOnReset     = 16'd40;
  localparam logic [CfgTimerWidth-1:0] PlasmaCycleReset  = 16'd8000;
  localparam logic [CfgTimerWidth-1:0] BlinkOnReset      = 16'd4000;
  localparam logic [CfgTimerWidth-1:0] BlinkCycleReset   = 16'd8000;

  // register index (word address)
  localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [2:0] REG_HOLD         = 3'd1;
  localparam logic [2:0] REG_BATTERY_LOW  = 3'd2;
  localparam logic [2:0] REG_PLASMA_ON    = 3'd3;
  localparam logic [2:0] REG_PLASMA_CYCLE = 3'd4;
  localparam logic [2:0] REG_BLINK_ON     = 3'd5;
  localparam logic [2:0] REG_BLINK_CYCLE  = 3'd6;

  // bit positions in the drive vector
  localparam int DrvPlasma = 0;
  localparam int DrvSupply = 1;
  localparam int DrvFan    = 2;
  localparam int DrvBlue   = 3;
  localparam int DrvUv     = 4;
  localparam int DrvRed    = 5;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_PLASMA = 2'd1,
    MODE_SLEEP  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CHG_NONE = 2'd0,
    CHG_NEED = 2'd1,
    CHG_DO   = 2'd2
  } charge_t;

  typedef struct packed {
    logic                    touch_level;
    logic                    charger_level;
    logic [BatteryWidth-1:0] battery_level;
  } tick_t;

  typedef struct packed {
    logic       plasma_on;
    logic       supply_on;
    logic       fan_on;
    logic       blue_on;
    logic       uv_on;
    logic       red_on;
    logic [1:0] mode_now;
    logic [1:0] charge_state;
  } result_t;

endpackage

@@ design/touch_mode_pulse_controller.sv @@
`timescale 1ns / 1ps

// Touch-key mode controller with plasma burst and red-LED blink timing. Every
// accepted tick beat advances the burst and blink timers, debounces the touch
// pin (a settled long press steps normal -> plasma -> sleep -> plasma, locked
// until a settled release), classifies the charge state from the charger pin
// and battery sample, and applies a plasma entry, all in one combinational pass
// from the state registers to the result register. One tick is taken per clock
// while tick_stall is low, and its result beat is registered. A two-entry output
// stage (result register plus skid register) lets a tick be accepted while a
// finished result is still stalled; tick_stall rises only when both entries are
// full. Configuration is written through an APB-style port (registers at byte
// address 4*index); the user must write it only while idle, which the block
// does not enforce. The burst and blink counters are TIMER_WIDTH bits and wrap.

`include "assert_macros.svh"

module touch_mode_pulse_controller #(
  parameter int TIMER_WIDTH = tmpc_pkg::TimerWidthDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  // tick channel
  input  logic                                tick_valid,
  output logic                                tick_stall,
  input  tmpc_pkg::tick_t                     tick,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output tmpc_pkg::result_t                   result,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tmpc_pkg::PaddrWidth-1:0]     paddr,
  input  logic [tmpc_pkg::ApbDataWidth-1:0]   pwdata,
  output logic [tmpc_pkg::ApbDataWidth-1:0]   prdata,
  output logic                                pready
);

  import tmpc_pkg::*;

  // compare width covers both the counter and the 16-bit register
  localparam int CmpW = (TIMER_WIDTH > CfgTimerWidth) ? TIMER_WIDTH : CfgTimerWidth;

  // configuration registers
  logic [7:0]               debounce_ticks;
  logic [7:0]               hold_steps;
  logic [BatteryWidth-1:0]  battery_low_level;
  logic [CfgTimerWidth-1:0] plasma_on_ticks;
  logic [CfgTimerWidth-1:0] plasma_cycle_ticks;
  logic [CfgTimerWidth-1:0] blink_on_ticks;
  logic [CfgTimerWidth-1:0] blink_cycle_ticks;

  // controller state
  logic                   last_touch, last_touch_next;
  logic [7:0]             settle_count, settle_count_next;
  logic [7:0]             hold_count, hold_count_next;
  logic                   key_locked, key_locked_next;
  mode_t                  mode_reg, mode_reg_next;
  logic                   blink_enable, blink_enable_next;
  logic                   plasma_enable, plasma_enable_next;
  charge_t                charge_reg, charge_reg_next;
  logic [TIMER_WIDTH-1:0] plasma_count, plasma_count_next;
  logic [TIMER_WIDTH-1:0] blink_count, blink_count_next;
  logic [5:0]             drive_outputs, drive_outputs_next;

  // output stage
  logic    skid_valid;
  result_t skid;
  result_t result_next;
  logic    tick_take;
  logic    write_en;
  logic [2:0] reg_index;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign write_en  = psel && penable && pwrite && pready;
  assign reg_index = paddr[PaddrWidth-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= DebounceReset;
      hold_steps         <= HoldReset;
      battery_low_level  <= BatteryLowReset;
      plasma_on_ticks    <= PlasmaOnReset;
      plasma_cycle_ticks <= PlasmaCycleReset;
      blink_on_ticks     <= BlinkOnReset;
      blink_cycle_ticks  <= BlinkCycleReset;
    end else if (write_en) begin
      case (reg_index)
        REG_DEBOUNCE:     debounce_ticks     <= pwdata[7:0];
        REG_HOLD:         hold_steps         <= pwdata[7:0];
        REG_BATTERY_LOW:  battery_low_level  <= pwdata[BatteryWidth-1:0];
        REG_PLASMA_ON:    plasma_on_ticks    <= pwdata[CfgTimerWidth-1:0];
        REG_PLASMA_CYCLE: plasma_cycle_ticks <= pwdata[CfgTimerWidth-1:0];
        REG_BLINK_ON:     blink_on_ticks     <= pwdata[CfgTimerWidth-1:0];
        REG_BLINK_CYCLE:  blink_cycle_ticks  <= pwdata[CfgTimerWidth-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_index)
      REG_DEBOUNCE:     prdata = ApbDataWidth'(debounce_ticks);
      REG_HOLD:         prdata = ApbDataWidth'(hold_steps);
      REG_BATTERY_LOW:  prdata = ApbDataWidth'(battery_low_level);
      REG_PLASMA_ON:    prdata = ApbDataWidth'(plasma_on_ticks);
      REG_PLASMA_CYCLE: prdata = ApbDataWidth'(plasma_cycle_ticks);
      REG_BLINK_ON:     prdata = ApbDataWidth'(blink_on_ticks);
      REG_BLINK_CYCLE:  prdata = ApbDataWidth'(blink_cycle_ticks);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: stall only when both output entries hold results
  // ---------------------------------------------------------------------------
  assign tick_stall = skid_valid;
  assign tick_take  = tick_valid && !tick_stall;

  // ---------------------------------------------------------------------------
  // tick update, the five steps in order on blocking variables
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [8:0] hold_inc;
    logic       plasma_entry;

    last_touch_next    = last_touch;
    settle_count_next  = settle_count;
    hold_count_next    = hold_count;
    key_locked_next    = key_locked;
    mode_reg_next      = mode_reg;
    blink_enable_next  = blink_enable;
    plasma_enable_next = plasma_enable;
    charge_reg_next    = charge_reg;
    plasma_count_next  = plasma_count;
    blink_count_next   = blink_count;
    drive_outputs_next = drive_outputs;
    plasma_entry       = 1'b0;
    hold_inc           = {1'b0, hold_count} + 9'd1;

    // burst timer
    if (plasma_enable && (mode_reg == MODE_PLASMA)) begin
      plasma_count_next = plasma_count + TIMER_WIDTH'(1);
      if (CmpW'(plasma_count_next) == CmpW'(plasma_on_ticks)) begin
        drive_outputs_next[DrvPlasma] = 1'b0;
      end
      if (CmpW'(plasma_count_next) == CmpW'(plasma_cycle_ticks)) begin
        drive_outputs_next[DrvPlasma] = 1'b1;
        plasma_count_next             = '0;
      end
    end

    // red blink timer
    if (blink_enable) begin
      case (charge_reg)
        CHG_NONE: drive_outputs_next[DrvRed] = 1'b0;
        CHG_NEED: begin
          blink_count_next = blink_count + TIMER_WIDTH'(1);
          if (CmpW'(blink_count_next) == CmpW'(blink_on_ticks)) begin
            drive_outputs_next[DrvRed] = 1'b0;
          end
          if (CmpW'(blink_count_next) == CmpW'(blink_cycle_ticks)) begin
            drive_outputs_next[DrvRed] = 1'b1;
            blink_count_next           = '0;
          end
        end
        CHG_DO:   drive_outputs_next[DrvRed] = 1'b1;
        default: ;
      endcase
    end

    // touch key debounce and long press
    if (tick.touch_level == last_touch) begin
      settle_count_next = settle_count + 8'd1;
      if (settle_count_next > debounce_ticks) begin
        settle_count_next = '0;
        if (!last_touch) begin
          if (!key_locked) begin
            hold_count_next = hold_inc[8] ? 8'hff : hold_inc[7:0];
            if (hold_inc > {1'b0, hold_steps}) begin
              key_locked_next = 1'b1;
              case (mode_reg)
                MODE_NORMAL: mode_reg_next = MODE_PLASMA;
                MODE_PLASMA: mode_reg_next = MODE_SLEEP;
                default:     mode_reg_next = MODE_PLASMA;
              endcase
              if (mode_reg_next == MODE_PLASMA) begin
                blink_enable_next  = 1'b1;
                plasma_enable_next = 1'b1;
                plasma_entry       = 1'b1;
              end else begin
                drive_outputs_next = '0;
                blink_enable_next  = 1'b0;
                plasma_enable_next = 1'b0;
                plasma_count_next  = '0;
              end
            end
          end
        end else begin
          key_locked_next = 1'b0;
          hold_count_next = '0;
        end
      end
    end else begin
      last_touch_next   = tick.touch_level;
      settle_count_next = '0;
      hold_count_next   = '0;
    end

    // charge classification
    if (tick.charger_level) begin
      charge_reg_next              = CHG_DO;
      drive_outputs_next[DrvRed]   = 1'b1;
    end else if (tick.battery_level < battery_low_level) begin
      if (!blink_enable_next) begin
        drive_outputs_next[DrvRed] = 1'b0;
      end
      charge_reg_next = CHG_NEED;
    end else begin
      charge_reg_next            = CHG_NONE;
      drive_outputs_next[DrvRed] = 1'b0;
      blink_count_next           = '0;
    end

    // plasma entry switches on everything but red
    if (plasma_entry) begin
      drive_outputs_next[DrvSupply] = 1'b1;
      drive_outputs_next[DrvPlasma] = 1'b1;
      drive_outputs_next[DrvBlue]   = 1'b1;
      drive_outputs_next[DrvFan]    = 1'b1;
      drive_outputs_next[DrvUv]     = 1'b1;
      plasma_enable_next            = 1'b1;
      plasma_count_next             = '0;
    end
  end

  always_comb begin
    result_next.plasma_on    = drive_outputs_next[DrvPlasma];
    result_next.supply_on    = drive_outputs_next[DrvSupply];
    result_next.fan_on       = drive_outputs_next[DrvFan];
    result_next.blue_on      = drive_outputs_next[DrvBlue];
    result_next.uv_on        = drive_outputs_next[DrvUv];
    result_next.red_on       = drive_outputs_next[DrvRed];
    result_next.mode_now     = mode_reg_next;
    result_next.charge_state = charge_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_touch    <= 1'b0;
      settle_count  <= '0;
      hold_count    <= '0;
      key_locked    <= 1'b0;
      mode_reg      <= MODE_NORMAL;
      blink_enable  <= 1'b0;
      plasma_enable <= 1'b0;
      charge_reg    <= CHG_NONE;
      plasma_count  <= '0;
      blink_count   <= '0;
      drive_outputs <= '0;
    end else if (tick_take) begin
      last_touch    <= last_touch_next;
      settle_count  <= settle_count_next;
      hold_count    <= hold_count_next;
      key_locked    <= key_locked_next;
      mode_reg      <= mode_reg_next;
      blink_enable  <= blink_enable_next;
      plasma_enable <= plasma_enable_next;
      charge_reg    <= charge_reg_next;
      plasma_count  <= plasma_count_next;
      blink_count   <= blink_count_next;
      drive_outputs <= drive_outputs_next;
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: result register with a skid entry behind it
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (result_valid && result_stall) begin
        // result held; a new beat parks in the skid entry
        if (tick_take) begin
          skid_valid <= 1'b1;
        end
      end else if (skid_valid) begin
        // result taken or empty, skid moves up (tick_stall keeps new beats out)
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= tick_take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && result_stall) begin
      if (tick_take) begin
        skid <= result_next;
      end
    end else if (skid_valid) begin
      result <= skid;
    end else if (tick_take) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `CHECK_ALWAYS(a_skid_behind_result, !skid_valid || result_valid,
                "skid entry full while result register empty")
  `CHECK_NEXT(a_stalled_beat_parks, tick_take && result_valid && result_stall,
              skid_valid, "beat accepted under a stalled result was not parked")
  `CHECK_ALWAYS(a_lock_only_after_normal, !key_locked || (mode_reg != MODE_NORMAL),
                "key lock set while still in normal mode")
  `CHECK_ALWAYS(a_sleep_timers_off,
                (mode_reg != MODE_SLEEP) || (!plasma_enable && !blink_enable),
                "timer enabled in sleep mode")
  `CHECK_ALWAYS(a_plasma_timers_on,
                (mode_reg != MODE_PLASMA) || (plasma_enable && blink_enable),
                "timer disabled in plasma mode")

endmodule

@@ bench/touch_mode_pulse_controller_tb.sv @@
`timescale 1ns / 1ps

module touch_mode_pulse_controller_tb;
  import tmpc_pkg::*;

  // cycles without any accepted beat before the run is declared hung
  localparam int QuietLimit = 2000;
  // address slot past the last register, writes there must be dropped
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // charger and battery flavor used for a run of ticks
  typedef enum int {
    SCENE_LOW,
    SCENE_CHARGING,
    SCENE_FULL,
    SCENE_MIXED
  } scene_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic    tick_valid = 1'b0;
  logic    tick_stall;
  tick_t   tick = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PaddrWidth-1:0]   paddr = '0;
  logic [ApbDataWidth-1:0] pwdata = '0;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  touch_mode_pulse_controller dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the controller: settings and state
  // ---------------------------------------------------------------------------
  logic [7:0]               cfg_debounce = DebounceReset;
  logic [7:0]               cfg_hold = HoldReset;
  logic [BatteryWidth-1:0]  cfg_batt_low = BatteryLowReset;
  logic [CfgTimerWidth-1:0] cfg_plasma_on = PlasmaOnReset;
  logic [CfgTimerWidth-1:0] cfg_plasma_cycle = PlasmaCycleReset;
  logic [CfgTimerWidth-1:0] cfg_blink_on = BlinkOnReset;
  logic [CfgTimerWidth-1:0] cfg_blink_cycle = BlinkCycleReset;

  logic                          touch_seen = 1'b0;  // starts as pressed
  logic [7:0]                    settle_cnt = '0;
  logic [7:0]                    hold_cnt = '0;
  logic                          key_locked = 1'b0;
  mode_t                         mode_s = MODE_NORMAL;
  logic                          blink_en = 1'b0;
  logic                          burst_en = 1'b0;
  charge_t                       charge_s = CHG_NONE;
  logic [TimerWidthDefault-1:0]  burst_cnt = '0;
  logic [TimerWidthDefault-1:0]  blink_cnt = '0;
  logic [5:0]                    drives = '0;

  tick_t   pending_ticks[$];
  result_t expected_results[$];

  int          errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  scene_t      scene = SCENE_MIXED;
  bit          tick_fired = 1'b0;
  bit          result_fired = 1'b0;
  int unsigned quiet_cycles = 0;

  // one tick through the controller: timers, touch key, charge, plasma entry
  function automatic result_t advance_tick(input tick_t t);
    result_t r;
    logic [8:0] next_hold;
    logic entering;
    entering = 1'b0;

    // burst and blink timers
    if (burst_en && mode_s == MODE_PLASMA) begin
      burst_cnt = burst_cnt + TimerWidthDefault'(1);
      if (burst_cnt == cfg_plasma_on) drives[DrvPlasma] = 1'b0;
      if (burst_cnt == cfg_plasma_cycle) begin
        drives[DrvPlasma] = 1'b1;
        burst_cnt = '0;
      end
    end
    if (blink_en) begin
      case (charge_s)
        CHG_NONE: drives[DrvRed] = 1'b0;
        CHG_NEED: begin
          blink_cnt = blink_cnt + TimerWidthDefault'(1);
          if (blink_cnt == cfg_blink_on) drives[DrvRed] = 1'b0;
          if (blink_cnt == cfg_blink_cycle) begin
            drives[DrvRed] = 1'b1;
            blink_cnt = '0;
          end
        end
        CHG_DO: drives[DrvRed] = 1'b1;
        default: ;
      endcase
    end

    // touch debounce and long-press mode stepping
    if (t.touch_level == touch_seen) begin
      settle_cnt = settle_cnt + 8'd1;
      if (settle_cnt > cfg_debounce) begin
        settle_cnt = '0;
        if (!touch_seen) begin
          if (!key_locked) begin
            next_hold = {1'b0, hold_cnt} + 9'd1;
            hold_cnt = next_hold[8] ? 8'hFF : next_hold[7:0];
            if (next_hold > {1'b0, cfg_hold}) begin
              key_locked = 1'b1;
              mode_s = (mode_s >= MODE_SLEEP) ? MODE_PLASMA : mode_t'(mode_s + 2'd1);
              if (mode_s == MODE_PLASMA) begin
                blink_en = 1'b1;
                burst_en = 1'b1;
                entering = 1'b1;
              end else if (mode_s == MODE_SLEEP) begin
                drives = '0;
                blink_en = 1'b0;
                burst_en = 1'b0;
                burst_cnt = '0;
              end
            end
          end
        end else begin
          key_locked = 1'b0;
          hold_cnt = '0;
        end
      end
    end else begin
      touch_seen = t.touch_level;
      settle_cnt = '0;
      hold_cnt = '0;
    end

    // charge classification
    if (t.charger_level) begin
      charge_s = CHG_DO;
      drives[DrvRed] = 1'b1;
    end else if (t.battery_level < cfg_batt_low) begin
      if (!blink_en) drives[DrvRed] = 1'b0;
      charge_s = CHG_NEED;
    end else begin
      charge_s = CHG_NONE;
      drives[DrvRed] = 1'b0;
      blink_cnt = '0;
    end

    // plasma entry switches every drive but red on
    if (entering && mode_s == MODE_PLASMA) begin
      drives[DrvSupply] = 1'b1;
      drives[DrvPlasma] = 1'b1;
      drives[DrvBlue] = 1'b1;
      drives[DrvFan] = 1'b1;
      drives[DrvUv] = 1'b1;
      burst_en = 1'b1;
      burst_cnt = '0;
    end

    r.plasma_on = drives[DrvPlasma];
    r.supply_on = drives[DrvSupply];
    r.fan_on = drives[DrvFan];
    r.blue_on = drives[DrvBlue];
    r.uv_on = drives[DrvUv];
    r.red_on = drives[DrvRed];
    r.mode_now = mode_s;
    r.charge_state = charge_s;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [1:0] want,
                                        input logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // tick driver: changes on the falling edge, holds a stalled beat
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!tick_valid || tick_fired)) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        tick <= pending_ticks.pop_front();
        tick_valid <= 1'b1;
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each accepted tick, checks each accepted result,
  // and keeps the hang watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tick_fired = 1'b0;
    result_fired = 1'b0;
    if (!rst) begin
      if (tick_valid && !tick_stall) begin
        tick_fired = 1'b1;
        expected_results.push_back(advance_tick(tick));
      end
      if (result_valid && !result_stall) begin
        result_fired = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result beat with no tick waiting for it");
          errors++;
        end else begin
          result_t want;
          want = expected_results.pop_front();
          compare_field("plasma_on", want.plasma_on, result.plasma_on);
          compare_field("supply_on", want.supply_on, result.supply_on);
          compare_field("fan_on", want.fan_on, result.fan_on);
          compare_field("blue_on", want.blue_on, result.blue_on);
          compare_field("uv_on", want.uv_on, result.uv_on);
          compare_field("red_on", want.red_on, result.red_on);
          compare_field("mode_now", want.mode_now, result.mode_now);
          compare_field("charge_state", want.charge_state, result.charge_state);
        end
      end
      // watchdog: a correct run never sits this long without a beat
      if (tick_fired || result_fired) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // register access
  // ---------------------------------------------------------------------------
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // mirror the write in the shadow settings
    case (idx)
      REG_DEBOUNCE:     cfg_debounce = val[7:0];
      REG_HOLD:         cfg_hold = val[7:0];
      REG_BATTERY_LOW:  cfg_batt_low = val[BatteryWidth-1:0];
      REG_PLASMA_ON:    cfg_plasma_on = val[CfgTimerWidth-1:0];
      REG_PLASMA_CYCLE: cfg_plasma_cycle = val[CfgTimerWidth-1:0];
      REG_BLINK_ON:     cfg_blink_on = val[CfgTimerWidth-1:0];
      REG_BLINK_CYCLE:  cfg_blink_cycle = val[CfgTimerWidth-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reg_check(input logic [2:0] idx, input logic [31:0] want);
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $error("register %0d: expected %0d, got %0d", idx, want, got);
      errors++;
    end
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
    reg_write(idx, val);
    reg_check(idx, val);
  endtask

  task automatic apply_settings(input int unsigned d, h, bl, pon, pcyc, bon, bcyc);
    program_reg(REG_DEBOUNCE, d);
    program_reg(REG_HOLD, h);
    program_reg(REG_BATTERY_LOW, bl);
    program_reg(REG_PLASMA_ON, pon);
    program_reg(REG_PLASMA_CYCLE, pcyc);
    program_reg(REG_BLINK_ON, bon);
    program_reg(REG_BLINK_CYCLE, bcyc);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  task automatic queue_tick(input logic touch, input logic charger,
                            input logic [BatteryWidth-1:0] battery);
    tick_t t;
    t.touch_level = touch;
    t.charger_level = charger;
    t.battery_level = battery;
    pending_ticks.push_back(t);
  endtask

  // charger and battery follow the current scene, with an odd stray tick
  task automatic queue_scene_tick(input logic touch);
    scene_t pick;
    pick = ($urandom_range(19) == 0) ? SCENE_MIXED : scene;
    case (pick)
      SCENE_LOW:
        queue_tick(touch, 1'b0, (cfg_batt_low == 0) ? 10'($urandom_range(1023))
                                                    : 10'($urandom_range(cfg_batt_low - 1, 0)));
      SCENE_CHARGING: queue_tick(touch, 1'b1, 10'($urandom_range(1023)));
      SCENE_FULL:     queue_tick(touch, 1'b0, 10'($urandom_range(1023, cfg_batt_low)));
      default:        queue_tick(touch, 1'($urandom_range(1)), 10'($urandom));
    endcase
  endtask

  // mostly full long presses followed by a settled release, some cut short at or
  // before the mode step, the rest raw touch chatter
  task automatic queue_random(input int count);
    int added;
    int press_len;
    int release_len;
    int need;
    added = 0;
    while (added < count) begin
      scene = scene_t'($urandom_range(3));
      need = (cfg_debounce + 1) * (cfg_hold + 1) + 1;
      if ($urandom_range(9) < 7) begin
        press_len = need + $urandom_range(6);
        if ($urandom_range(4) == 0) press_len = $urandom_range(need, 1);
        release_len = cfg_debounce + 2 + $urandom_range(6);
        repeat (press_len) queue_scene_tick(1'b0);
        repeat (release_len) queue_scene_tick(1'b1);
        added += press_len + release_len;
      end else begin
        release_len = $urandom_range(8, 1);
        repeat (release_len) queue_scene_tick(1'($urandom_range(1)));
        added += release_len;
      end
    end
  endtask

  // sender holds off until every queued tick has its result back
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || tick_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    int k;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers come up at their reset values
    reg_check(REG_DEBOUNCE, DebounceReset);
    reg_check(REG_HOLD, HoldReset);
    reg_check(REG_BATTERY_LOW, BatteryLowReset);
    reg_check(REG_PLASMA_ON, PlasmaOnReset);
    reg_check(REG_PLASMA_CYCLE, PlasmaCycleReset);
    reg_check(REG_BLINK_ON, BlinkOnReset);
    reg_check(REG_BLINK_CYCLE, BlinkCycleReset);

    // reset settings: key held from reset counts as pressed, battery extremes
    // and both sides of the low-battery threshold
    queue_tick(1'b0, 1'b0, 10'd0);
    queue_tick(1'b0, 1'b0, 10'd1023);
    queue_tick(1'b0, 1'b1, 10'h155);
    queue_tick(1'b1, 1'b0, 10'd674);
    queue_tick(1'b1, 1'b0, 10'd675);
    queue_tick(1'b1, 1'b1, 10'h2AA);
    wait_drained();

    // shortest debounce and hold, one-tick cycles, highest battery threshold;
    // the slot past the last register must ignore writes
    apply_settings(0, 0, 1023, 0, 1, 0, 1);
    reg_write(REG_UNUSED, $urandom);

    // press to plasma, hold while locked, release, press to sleep,
    // release, press back to plasma
    queue_tick(1'b0, 1'b0, 10'd0);
    queue_tick(1'b0, 1'b0, 10'd0);
    queue_tick(1'b0, 1'b0, 10'd500);
    queue_tick(1'b0, 1'b1, 10'd1023);
    queue_tick(1'b0, 1'b0, 10'd1023);
    queue_tick(1'b1, 1'b0, 10'd1022);
    queue_tick(1'b1, 1'b0, 10'd1022);
    queue_tick(1'b0, 1'b1, 10'd0);
    queue_tick(1'b0, 1'b1, 10'd0);
    queue_tick(1'b1, 1'b0, 10'd0);
    queue_tick(1'b1, 1'b0, 10'd0);
    queue_tick(1'b0, 1'b0, 10'd0);
    queue_tick(1'b0, 1'b0, 10'd0);
    queue_tick(1'b1, 1'b0, 10'd700);
    queue_tick(1'b1, 1'b0, 10'd700);
    queue_tick(1'b1, 1'b1, 10'd1023);
    wait_drained();

    // random phases, each with fresh settings and its own idling pattern
    for (phase = 0; phase < 10; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 84; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 84; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase

      if (phase == 0) begin
        // top debounce: the settle count wraps, so the key never settles
        apply_settings(255, 0, $urandom_range(1023), 3, 9, 2, 6);
        for (k = 0; k < 9; k++) begin
          scene = scene_t'($urandom_range(3));
          repeat (30) queue_scene_tick(1'b0);
        end
      end else if (phase == 1) begin
        // hold of 254, one short of the top, with no debounce
        apply_settings(0, 254, $urandom_range(1023), 5, 11, 4, 9);
        queue_random(250);
      end else if (phase == 6) begin
        // widest timer settings
        apply_settings($urandom_range(3), $urandom_range(4), $urandom_range(1023),
                       65535, 65535, 65535, 65535);
        queue_random(40);
      end else begin
        apply_settings($urandom_range(3), $urandom_range(4),
                       (phase == 4) ? 0 : (phase == 7) ? 1023 : $urandom_range(1023),
                       $urandom_range(10), $urandom_range(12, 1),
                       $urandom_range(10), $urandom_range(12, 1));
        queue_random(40);
      end
      wait_drained();
    end

    // let any stray result beat surface before the verdict
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
